@@ src/lcrd_pkg.sv @@
// Shared types and constants of the LED command and rainbow driver.
`default_nettype none

package lcrd_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_char;
  } in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [1:0] status_code;
    logic       last_of_run;
  } out_t;

  // Request types
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_COLOUR   = 2'd0;
  localparam logic [1:0] STAT_RAINBOW  = 2'd1;
  localparam logic [1:0] STAT_TOO_LONG = 2'd2;
  localparam logic [1:0] STAT_FORMAT   = 2'd3;

  // Register indexes
  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_OFFSET     = 1'b1;

  localparam logic [4:0] BRIGHTNESS_RESET = 5'd1;
  localparam logic [7:0] OFFSET_RESET     = 8'd25;

  // Characters
  localparam logic [7:0] CHAR_DEL   = 8'd127;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_SIX   = 8'h36;
  localparam logic [7:0] CHAR_EIGHT = 8'h38;
  localparam logic [7:0] ECHO_LOW   = 8'd20;

  localparam logic [7:0] HDR_MARK   = 8'hE0;

  localparam int unsigned RAINBOW_LEN = 12;
  localparam logic [8*RAINBOW_LEN-1:0] RAINBOW_WORD = "#FULLRAINBOW";

endpackage

`default_nettype wire

@@ src/lcrd_ram.sv @@
// Generic single-port-write RAM with registered read.
`default_nettype none

module lcrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/led_command_and_rainbow_driver.sv @@
// Top level: line editor, command parser, color wheel and strip frame generator.
// A character is dispatched, then gives up to 3 results, one per cycle unless stalled.
// A carriage return scans the line, each character read from RAM and then checked,
// at most 13 characters, then emits 1 result, or a frame of 8+4*LED_COUNT bytes plus status.
// A tick uses the shared color wheel unit, then one frame byte per cycle unless stalled.
// Reset: line empty, all LEDs off, rainbow off, position 0; the line RAM is not cleared.
`default_nettype none

module led_command_and_rainbow_driver #(
  parameter int unsigned LINE_LENGTH = 15,
  parameter int unsigned LED_COUNT   = 3
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire lcrd_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output lcrd_pkg::out_t       out_data_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic      [31:0]     prdata,
  output logic                 pready
);

  import lcrd_pkg::*;

  localparam int unsigned ADDR_W    = $clog2(LINE_LENGTH);
  localparam int unsigned CNT_W     = $clog2(LINE_LENGTH + 1);
  localparam int unsigned LED_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned FRAME_LEN = 8 + 4 * LED_COUNT;
  localparam int unsigned FCNT_W    = $clog2(FRAME_LEN);
  localparam int unsigned SCAN_MAX  = RAINBOW_LEN + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_ECHO = 4'd2;
  localparam logic [3:0] S_STAT = 4'd3;
  localparam logic [3:0] S_DEL  = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_DEC  = 4'd7;
  localparam logic [3:0] S_WHL0 = 4'd8;
  localparam logic [3:0] S_WHL1 = 4'd9;
  localparam logic [3:0] S_FRM  = 4'd10;

  function automatic logic [23:0] wheel(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
    logic [23:0] c;
    p = ~pos;
    if (p < 8'd85) begin
      q = p;
    end else if (p < 8'd170) begin
      q = p - 8'd85;
    end else begin
      q = p - 8'd170;
    end
    t = {q[6:0], 1'b0} + q;
    if (p < 8'd85) begin
      c = {8'd255 - t, 8'd0, t};
    end else if (p < 8'd170) begin
      c = {8'd0, t, 8'd255 - t};
    end else begin
      c = {t, 8'd255 - t, 8'd0};
    end
    return c;
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    // {valid, value}
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r = {1'b1, 4'(ch - 8'h37)};
    end
    return r;
  endfunction

  logic [3:0]        state_q, state_d;
  logic              type_q, type_d;
  logic [7:0]        char_q, char_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  lim_q, lim_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              full_q, full_d;
  logic [1:0]        stat_q, stat_d;
  logic [1:0]        dcnt_q, dcnt_d;
  logic              rb_ok_q, rb_ok_d;
  logic              fmt_ok_q, fmt_ok_d;
  logic [23:0]       col_q, col_d;
  logic [LED_W-1:0]  led_q, led_d;
  logic [FCNT_W-1:0] fcnt_q, fcnt_d;
  logic              fstat_q, fstat_d;
  logic              rainbow_q, rainbow_d;
  logic [7:0]        pos_q, pos_d;
  logic [23:0]       leds_q [LED_COUNT];
  logic [23:0]       leds_d [LED_COUNT];
  logic [4:0]        bright_q;
  logic [7:0]        off_q;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic              ram_we;
  logic [7:0]        ram_rdata;
  logic [CNT_W-1:0]  cnt_inc;
  logic              slot_free;
  logic [7:0]        whl_in;
  logic [23:0]       whl_out;
  logic [4:0]        hex;
  logic [7:0]        rb_char;
  logic [7:0]        digit;
  logic [FCNT_W-1:0] fj;
  logic [LED_W-1:0]  fled;
  logic [23:0]       fcol;
  logic [7:0]        fbyte;
  logic              cfg_wr;

  lcrd_ram #(
    .WIDTH(8),
    .DEPTH(LINE_LENGTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[ADDR_W-1:0]),
    .wdata_i(char_q),
    .raddr_i(idx_q[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_OFFSET) ? {24'd0, off_q} : {27'd0, bright_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= BRIGHTNESS_RESET;
      off_q    <= OFFSET_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BRIGHTNESS) begin
        bright_q <= pwdata[4:0];
      end else begin
        off_q <= pwdata[7:0];
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign cnt_inc     = cnt_q + 1'b1;

  // Shared color wheel unit: LED 0 first, then the lagging LEDs
  assign whl_in  = (state_q == S_WHL0) ? pos_q : pos_q - off_q;
  assign whl_out = wheel(whl_in);

  assign hex     = hex_digit(ram_rdata);
  assign rb_char = RAINBOW_WORD[(RAINBOW_LEN - 1 - int'(idx_q)) * 8 +: 8];
  assign digit   = ram_rdata - CHAR_SIX;

  // Frame byte select
  assign fj   = fcnt_q - FCNT_W'(4);
  assign fled = LED_W'(fj >> 2);
  assign fcol = leds_q[fled];
  always_comb begin
    if (fcnt_q < FCNT_W'(4)) begin
      fbyte = 8'h00;
    end else if (fcnt_q < FCNT_W'(4 + 4 * LED_COUNT)) begin
      case (fj[1:0])
        2'd0:    fbyte = HDR_MARK | {3'd0, bright_q};
        2'd1:    fbyte = fcol[7:0];
        2'd2:    fbyte = fcol[15:8];
        default: fbyte = fcol[23:16];
      endcase
    end else begin
      fbyte = 8'hFF;
    end
  end

  always_comb begin
    state_d     = state_q;
    type_d      = type_q;
    char_d      = char_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    idx_d       = idx_q;
    full_d      = full_q;
    stat_d      = stat_q;
    dcnt_d      = dcnt_q;
    rb_ok_d     = rb_ok_q;
    fmt_ok_d    = fmt_ok_q;
    col_d       = col_q;
    led_d       = led_q;
    fcnt_d      = fcnt_q;
    fstat_d     = fstat_q;
    rainbow_d   = rainbow_q;
    pos_d       = pos_q;
    leds_d      = leds_q;
    ram_we      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          type_d  = in_data_i.req_type;
          char_d  = in_data_i.rx_char;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (type_q == REQ_TICK) begin
          state_d = rainbow_q ? S_WHL0 : S_IDLE;
        end else if (char_q == CHAR_DEL) begin
          if (cnt_q == '0) begin
            state_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q - 1'b1;
            dcnt_d  = 2'd0;
            state_d = S_DEL;
          end
        end else if (char_q == CHAR_CR) begin
          lim_d    = cnt_q;
          cnt_d    = '0;
          idx_d    = '0;
          rb_ok_d  = 1'b1;
          fmt_ok_d = 1'b1;
          state_d  = S_RD;
        end else begin
          ram_we = 1'b1;
          full_d = (cnt_inc == CNT_W'(LINE_LENGTH));
          cnt_d  = full_d ? '0 : cnt_inc;
          stat_d = STAT_TOO_LONG;
          if (char_q >= ECHO_LOW && char_q < CHAR_DEL) begin
            state_d = S_ECHO;
          end else if (full_d) begin
            state_d = S_STAT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_ECHO: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_kind: KIND_ECHO, out_byte: char_q, status_code: 2'd0,
                          last_of_run: !full_q};
          state_d     = full_q ? S_STAT : S_IDLE;
        end
      end
      S_STAT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_kind: KIND_STATUS, out_byte: 8'd0, status_code: stat_q,
                          last_of_run: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_DEL: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_kind: KIND_ECHO,
                          out_byte: (dcnt_q == 2'd1) ? CHAR_SPACE : CHAR_BS,
                          status_code: 2'd0, last_of_run: (dcnt_q == 2'd2)};
          dcnt_d      = dcnt_q + 1'b1;
          if (dcnt_q == 2'd2) begin
            state_d = S_IDLE;
          end
        end
      end
      S_RD: begin
        // The read of idx_q is in flight; stop at the line end or once past the longest word
        if (idx_q == lim_q || idx_q == CNT_W'(SCAN_MAX)) begin
          state_d = S_DEC;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (ram_rdata == 8'd0) begin
          state_d = S_DEC;
        end else begin
          if (idx_q < CNT_W'(RAINBOW_LEN) && ram_rdata != rb_char) begin
            rb_ok_d = 1'b0;
          end
          if (idx_q == '0) begin
            if (ram_rdata != CHAR_HASH) fmt_ok_d = 1'b0;
          end else if (idx_q <= CNT_W'(6)) begin
            if (!hex[4]) fmt_ok_d = 1'b0;
            col_d = {col_q[19:0], hex[3:0]};
          end else if (idx_q == CNT_W'(7)) begin
            if (ram_rdata != CHAR_D) fmt_ok_d = 1'b0;
          end else if (idx_q == CNT_W'(8)) begin
            if (ram_rdata < CHAR_SIX || ram_rdata > CHAR_EIGHT ||
                digit >= 8'(LED_COUNT)) begin
              fmt_ok_d = 1'b0;
            end
            led_d = digit[LED_W-1:0];
          end
          idx_d   = idx_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_DEC: begin
        if (idx_q == CNT_W'(RAINBOW_LEN) && rb_ok_q) begin
          rainbow_d = 1'b1;
          stat_d    = STAT_RAINBOW;
          state_d   = S_STAT;
        end else if (idx_q >= CNT_W'(9) && fmt_ok_q) begin
          rainbow_d     = 1'b0;
          leds_d[led_q] = col_q;
          stat_d        = STAT_COLOUR;
          fstat_d       = 1'b1;
          fcnt_d        = '0;
          state_d       = S_FRM;
        end else begin
          stat_d  = STAT_FORMAT;
          state_d = S_STAT;
        end
      end
      S_WHL0: begin
        leds_d[0] = whl_out;
        state_d   = S_WHL1;
      end
      S_WHL1: begin
        for (int k = 1; k < LED_COUNT; k++) begin
          leds_d[k] = whl_out;
        end
        pos_d   = pos_q + 1'b1;
        fstat_d = 1'b0;
        fcnt_d  = '0;
        state_d = S_FRM;
      end
      S_FRM: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_kind: KIND_FRAME, out_byte: fbyte, status_code: 2'd0,
                          last_of_run: (fcnt_q == FCNT_W'(FRAME_LEN - 1)) && !fstat_q};
          fcnt_d      = fcnt_q + 1'b1;
          if (fcnt_q == FCNT_W'(FRAME_LEN - 1)) begin
            state_d = fstat_q ? S_STAT : S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rainbow_q   <= 1'b0;
      pos_q       <= 8'd0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < LED_COUNT; k++) begin
        leds_q[k] <= 24'd0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rainbow_q   <= rainbow_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      leds_q      <= leds_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q   <= type_d;
    char_q   <= char_d;
    lim_q    <= lim_d;
    idx_q    <= idx_d;
    full_q   <= full_d;
    stat_q   <= stat_d;
    dcnt_q   <= dcnt_d;
    rb_ok_q  <= rb_ok_d;
    fmt_ok_q <= fmt_ok_d;
    col_q    <= col_d;
    led_q    <= led_d;
    fcnt_q   <= fcnt_d;
    fstat_q  <= fstat_d;
    out_q    <= out_d;
  end

  // The line count never holds a full line
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(LINE_LENGTH))
    else $error("line count reached line length");

  // A status result always closes its run
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_kind == KIND_STATUS |-> out_data_o.last_of_run)
    else $error("status result not last of run");

  // A tick with rainbow off is dropped right after dispatch
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.req_type == REQ_TICK && !rainbow_q
    |-> ##2 in_ready_o)
    else $error("tick with rainbow off not dropped");

  // Carriage return empties the line
  a_cr_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.req_type == REQ_CHAR &&
    in_data_i.rx_char == CHAR_CR |-> ##2 cnt_q == '0)
    else $error("carriage return did not clear the line");

endmodule

`default_nettype wire
